@@ design/dvru_pkg.sv @@
// package: types, constants and codes shared by the route update unit
`default_nettype none
package dvru_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [30:0] MAX_COST = 31'h7FFF_FFFF;

  // func codes of an input word
  localparam logic FUNC_ADV = 1'b0;
  localparam logic FUNC_REQ = 1'b1;

  // msg_kind codes of a result word
  localparam logic KIND_ADV = 1'b0;
  localparam logic KIND_REQ = 1'b1;

  // status codes of a result word
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] domain_key;
    logic [15:0] via_system;
    logic [30:0] offered_cost;
  } item_t;

  typedef struct packed {
    logic        status;
    logic        msg_kind;
    logic        to_all;
    logic [15:0] target_system;
    logic [31:0] out_key;
    logic [30:0] out_cost;
  } result_t;

  // one route table entry as stored in memory
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] hop;
    logic        has_hop;
    logic [30:0] cost;
    logic        bad;
  } entry_t;

  // outcome of the shared comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage
`default_nettype wire

@@ design/dvru_ram.sv @@
// generic single-write, single-read memory with registered read data
`default_nettype none
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/dvru_cmp.sv @@
// shared 32-bit comparator: equality for the key search, less-than for costs
`default_nettype none
module dvru_cmp (
  input  wire logic [31:0]        a,
  input  wire logic [31:0]        b,
  output dvru_pkg::cmp_res_t      res
);

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule
`default_nettype wire

@@ design/distance_vector_route_update_unit.sv @@
// top level: route table, search sequencer and result register
`default_nettype none
// Distance-vector route table update. Each input word is a route advertisement
// or a route request for one destination key from one neighbor. The table
// holds up to dvru_pkg::ENTRIES routes in a single memory, searched one entry
// per cycle through its registered read port with one shared comparator. The
// search time of an item grows with its key's table position; an unknown key is
// compared with every stored entry before it is allocated or, when the table is
// full, dropped with a report. The linear scan of the memory sets the time per
// item. The block takes one item at a time: item_stall stays high from
// acceptance until the item's result (if any) is loaded into the output
// register, which waits only while an earlier result still sits there stalled.
// The table needs no clearing after reset; only entries below the fill count
// are ever used.
module distance_vector_route_update_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  // input words
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire dvru_pkg::item_t   item,
  // result words
  output logic                   result_valid,
  input  wire logic              result_stall,
  output dvru_pkg::result_t      result
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1; // compare one stored key per cycle
  localparam logic [2:0] ST_MISS = 3'd2; // key not found: allocate or flag full
  localparam logic [2:0] ST_HIT  = 3'd3; // decide update and message
  localparam logic [2:0] ST_OUT  = 3'd4; // hand result to output register

  logic [2:0]                   state;
  logic [dvru_pkg::CNT_W-1:0]   entry_count;
  logic [dvru_pkg::IDX_W-1:0]   idx;       // entry under compare in scan
  logic [dvru_pkg::IDX_W-1:0]   hit_idx;   // entry being updated
  dvru_pkg::item_t              cur;       // item held while it is worked on
  dvru_pkg::entry_t             ent;       // found or freshly made entry
  dvru_pkg::result_t            pend;      // result waiting for output register

  logic [dvru_pkg::IDX_W-1:0]   raddr;
  dvru_pkg::entry_t             rdata;
  logic                         we;
  dvru_pkg::entry_t             wdata;

  logic [31:0]                  cmp_a;
  logic [31:0]                  cmp_b;
  dvru_pkg::cmp_res_t           cmp;

  logic [dvru_pkg::CNT_W-1:0]   idx_inc;
  logic                         last;
  logic                         out_free;

  // decision made in the hit state
  dvru_pkg::entry_t             ent_next;
  dvru_pkg::result_t            res_next;
  logic                         res_have;

  // made on a miss: fresh entry, or the dropped-record report
  dvru_pkg::entry_t             new_ent;
  dvru_pkg::result_t            full_res;

  dvru_ram #(
    .WIDTH ($bits(dvru_pkg::entry_t)),
    .DEPTH (dvru_pkg::ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (hit_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // one comparator: stored key vs item key while scanning, costs in hit state
  always_comb begin
    if (state == ST_SCAN) begin
      cmp_a = rdata.key;
      cmp_b = cur.domain_key;
    end else begin
      cmp_a = {1'b0, cur.offered_cost};
      cmp_b = {1'b0, ent.cost};
    end
  end

  dvru_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  assign idx_inc    = {{(dvru_pkg::CNT_W - dvru_pkg::IDX_W){1'b0}}, idx} + 1'b1;
  assign last       = (idx_inc == entry_count);
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);

  // read address: entry 0 on acceptance, the following entry while scanning
  always_comb begin
    if (state == ST_SCAN) begin
      raddr = idx_inc[dvru_pkg::IDX_W-1:0];
    end else begin
      raddr = '0;
    end
  end

  // new entry: worst cost, no next hop, marked bad; full report: key only
  always_comb begin
    new_ent          = '0;
    new_ent.key      = cur.domain_key;
    new_ent.cost     = dvru_pkg::MAX_COST;
    new_ent.bad      = 1'b1;
    full_res         = '0;
    full_res.status  = dvru_pkg::STATUS_FULL;
    full_res.out_key = cur.domain_key;
  end

  // route decision for the entry in ent
  always_comb begin
    ent_next = ent;
    res_next = '0;
    res_have = 1'b0;
    res_next.status        = dvru_pkg::STATUS_OK;
    res_next.target_system = cur.via_system;
    res_next.out_key       = cur.domain_key;
    if (cur.func == dvru_pkg::FUNC_ADV) begin
      // better cost or bad route: take it and broadcast
      if (cmp.lt || ent.bad) begin
        ent_next.hop     = cur.via_system;
        ent_next.has_hop = 1'b1;
        ent_next.cost    = cur.offered_cost;
        ent_next.bad     = 1'b0;
        res_next.msg_kind = dvru_pkg::KIND_ADV;
        res_next.to_all   = 1'b1;
        res_next.out_cost = cur.offered_cost;
        res_have = 1'b1;
      end
    end else begin
      res_have = 1'b1;
      if (ent.has_hop && (ent.hop == cur.via_system)) begin
        // our next hop lost the route: mark bad and pass the request on
        ent_next.bad      = 1'b1;
        res_next.msg_kind = dvru_pkg::KIND_REQ;
        res_next.to_all   = 1'b1;
        res_next.out_cost = '0;
      end else begin
        // answer the sender with what we have
        res_next.msg_kind = dvru_pkg::KIND_ADV;
        res_next.to_all   = 1'b0;
        res_next.out_cost = ent.cost;
      end
    end
  end

  // entry is written back in every hit state, changed or not (new entries need it)
  assign we    = (state == ST_HIT);
  assign wdata = ent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      // load a new result, or empty the register once it is taken
      if ((state == ST_OUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur <= item;
            idx <= '0;
            if (entry_count == '0) begin
              state <= ST_MISS;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cmp.eq) begin
            ent     <= rdata;
            hit_idx <= idx;
            state   <= ST_HIT;
          end else if (last) begin
            state <= ST_MISS;
          end else begin
            idx <= idx_inc[dvru_pkg::IDX_W-1:0];
          end
        end
        ST_MISS: begin
          if (entry_count == dvru_pkg::CNT_W'(dvru_pkg::ENTRIES)) begin
            // table full: drop the record and report it
            pend  <= full_res;
            state <= ST_OUT;
          end else begin
            ent         <= new_ent;
            hit_idx     <= entry_count[dvru_pkg::IDX_W-1:0];
            entry_count <= entry_count + 1'b1;
            state       <= ST_HIT;
          end
        end
        ST_HIT: begin
          pend <= res_next;
          if (res_have) begin
            state <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload register: loads only when the output side is free
  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      result <= pend;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/distance_vector_route_update_unit_test.sv @@
// testbench: drives route words into the route update unit and checks every result word
module distance_vector_route_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dvru_pkg::*;

  // no-acceptance cycles before the run is declared hung; many times what a slow
  // item needs for its input gap, table search and result stall together
  localparam int IDLE_LIMIT    = 4000;
  // cycles to let a word with no result finish its search before moving on
  localparam int SETTLE_CYCLES = 150;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  distance_vector_route_update_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // shadow route table kept by the predictor
  entry_t      route_tbl [ENTRIES];
  int          route_fill = 0;
  // result words still owed by the block, oldest first
  result_t     owed_msgs [$];
  int          fail_count = 0;
  // when set, neither side inserts gaps or stalls
  bit          no_idle    = 1'b0;
  // destination keys the traffic mostly reuses
  logic [31:0] key_pool [$];
  // a handful of neighbors so that requests often come from the next hop
  logic [15:0] nbr_ids [6];

  initial begin
    forever #2 clk = ~clk;
  end

  // table update for one accepted word; returns 1 when a result word is owed
  function automatic bit predict_route(input item_t w, output result_t msg);
    int idx;
    int i;
    idx = route_fill;
    msg = '0;
    // linear search, first match wins
    for (i = 0; i < route_fill; i++) begin
      if (idx == route_fill && route_tbl[i].key == w.domain_key) idx = i;
    end
    msg.out_key = w.domain_key;
    if (idx == route_fill) begin
      // unknown key with no room left: word dropped and flagged
      if (route_fill >= ENTRIES) begin
        msg.status = STATUS_FULL;
        return 1'b1;
      end
      // unknown key: fresh entry, worst cost, no next hop, marked bad
      route_tbl[idx].key     = w.domain_key;
      route_tbl[idx].hop     = '0;
      route_tbl[idx].has_hop = 1'b0;
      route_tbl[idx].cost    = MAX_COST;
      route_tbl[idx].bad     = 1'b1;
      route_fill++;
    end
    msg.status        = STATUS_OK;
    msg.target_system = w.via_system;
    if (w.func == FUNC_ADV) begin
      // better cost or bad route: take it and broadcast it
      if (w.offered_cost < route_tbl[idx].cost || route_tbl[idx].bad) begin
        route_tbl[idx].hop     = w.via_system;
        route_tbl[idx].has_hop = 1'b1;
        route_tbl[idx].cost    = w.offered_cost;
        route_tbl[idx].bad     = 1'b0;
        msg.msg_kind = KIND_ADV;
        msg.to_all   = 1'b1;
        msg.out_cost = w.offered_cost;
        return 1'b1;
      end
      return 1'b0;
    end
    // request from our own next hop: route goes bad, pass the request on
    if (route_tbl[idx].has_hop && route_tbl[idx].hop == w.via_system) begin
      route_tbl[idx].bad = 1'b1;
      msg.msg_kind = KIND_REQ;
      msg.to_all   = 1'b1;
      msg.out_cost = '0;
      return 1'b1;
    end
    // any other request: answer the sender with what we hold
    msg.msg_kind = KIND_ADV;
    msg.to_all   = 1'b0;
    msg.out_cost = route_tbl[idx].cost;
    return 1'b1;
  endfunction

  function automatic item_t route_word(input logic f, input logic [31:0] k,
                                       input logic [15:0] v, input logic [30:0] c);
    item_t w;
    w.func         = f;
    w.domain_key   = k;
    w.via_system   = v;
    w.offered_cost = c;
    return w;
  endfunction

  // random word: known keys unless unknown_pct picks a fresh one, mostly known neighbors, costs mostly close together
  function automatic item_t random_route_word(input int unknown_pct);
    item_t w;
    int    pick;
    w.func = ($urandom_range(0, 99) < 45) ? FUNC_REQ : FUNC_ADV;
    if (key_pool.size() == 0 || $urandom_range(0, 99) < unknown_pct)
      w.domain_key = $urandom();
    else
      w.domain_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if ($urandom_range(0, 9) == 0)
      w.via_system = 16'($urandom());
    else
      w.via_system = nbr_ids[$urandom_range(0, 5)];
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        w.offered_cost = 31'($urandom());
      end
      1: begin
        w.offered_cost = MAX_COST;
      end
      2: begin
        w.offered_cost = '0;
      end
      default: begin
        w.offered_cost = 31'($urandom_range(0, 300));
      end
    endcase
    return w;
  endfunction

  // hand one word to the block; valid stays high when the next word follows at once
  task automatic send_word(input item_t w);
    int      gap;
    result_t msg;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (predict_route(w, msg)) owed_msgs.push_back(msg);
  endtask

  // stop sending and wait until every owed result word is in, plus search time
  task automatic settle_sender();
    item_valid <= 1'b0;
    @(posedge clk);
    while (owed_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes and every branch of the update rules, in a known order
  task automatic test_directed_cases();
    int i;
    for (i = 0; i < 6; i++) nbr_ids[i] = 16'($urandom());
    // request for a brand new key, sender equal to the blank hop value
    send_word(route_word(FUNC_REQ, 32'h0000_0000, 16'h0000, 31'h0000_0000));
    // bad entry takes even the worst cost
    send_word(route_word(FUNC_ADV, 32'h0000_0000, 16'h0001, MAX_COST));
    // equal cost is not better
    send_word(route_word(FUNC_ADV, 32'h0000_0000, 16'h0002, MAX_COST));
    send_word(route_word(FUNC_ADV, 32'h0000_0000, 16'h0002, 31'h7FFF_FFFE));
    // higher cost is not better
    send_word(route_word(FUNC_ADV, 32'h0000_0000, 16'h0003, MAX_COST));
    // request from a bystander gets the stored cost
    send_word(route_word(FUNC_REQ, 32'h0000_0000, 16'h0003, 31'h1234_5678));
    // request from the next hop marks the route bad
    send_word(route_word(FUNC_REQ, 32'h0000_0000, 16'h0002, 31'h0000_0000));
    // bad route accepts a worse offer
    send_word(route_word(FUNC_ADV, 32'h0000_0000, 16'hFFFF, MAX_COST));
    send_word(route_word(FUNC_REQ, 32'h0000_0000, 16'hFFFF, MAX_COST));
    // still the next hop after going bad
    send_word(route_word(FUNC_REQ, 32'h0000_0000, 16'hFFFF, 31'h0000_0000));
    send_word(route_word(FUNC_ADV, 32'hFFFF_FFFF, 16'hFFFF, 31'h0000_0000));
    send_word(route_word(FUNC_ADV, 32'hFFFF_FFFF, 16'h0000, 31'h0000_0000));
    send_word(route_word(FUNC_REQ, 32'hFFFF_FFFF, 16'h0000, MAX_COST));
    // new key by request, then offers with alternating bit patterns
    send_word(route_word(FUNC_REQ, 32'h1234_5678, 16'hFFFF, 31'h2AAA_AAAA));
    send_word(route_word(FUNC_ADV, 32'h1234_5678, 16'h5555, 31'h5555_5555));
    send_word(route_word(FUNC_ADV, 32'h1234_5678, 16'hAAAA, 31'h2AAA_AAAA));
    send_word(route_word(FUNC_REQ, 32'h1234_5678, 16'h5555, 31'h0000_0000));
    // next hop of value zero must still count as a next hop
    send_word(route_word(FUNC_ADV, 32'hA5A5_A5A5, 16'h0000, 31'h0000_0000));
    send_word(route_word(FUNC_REQ, 32'hA5A5_A5A5, 16'h0000, 31'h0000_0000));
    send_word(route_word(FUNC_REQ, 32'h5A5A_5A5A, 16'h0000, 31'h7FFF_0000));
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    key_pool.push_back(32'h1234_5678);
    key_pool.push_back(32'hA5A5_A5A5);
    key_pool.push_back(32'h5A5A_5A5A);
    settle_sender();
  endtask

  // random traffic over a key pool that stays below the table size
  task automatic test_random_traffic(input int count);
    int n;
    while (key_pool.size() < 40) key_pool.push_back($urandom());
    for (n = 0; n < count; n++) send_word(random_route_word(0));
  endtask

  // sender holds off until the block has delivered everything, then bursts
  task automatic test_drain_pause();
    int n;
    settle_sender();
    for (n = 0; n < 20; n++) send_word(random_route_word(0));
    settle_sender();
  endtask

  // back-to-back words with the result side never stalling
  task automatic test_quiet_burst(input int count);
    int n;
    no_idle = 1'b1;
    for (n = 0; n < count; n++) send_word(random_route_word(0));
    no_idle = 1'b0;
  endtask

  // fill every entry, then keep mixing unknown keys (dropped) with known ones
  task automatic test_table_full(input int count);
    int n;
    while (route_fill < ENTRIES) send_word(random_route_word(100));
    for (n = 0; n < count; n++) send_word(random_route_word(30));
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(220);
    test_drain_pause();
    test_quiet_burst(50);
    test_random_traffic(180);
    test_table_full(150);
    settle_sender();
    if (fail_count == 0) begin
      $display("distance_vector_route_update_unit verification clean");
    end else begin
      $display("distance_vector_route_update_unit verification failed");
    end
    $finish;
  end

  // result side: compare each accepted word with the oldest owed one, then
  // draw how long to stall before taking the next
  initial begin : result_check
    int      hold;
    result_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (owed_msgs.size() == 0) begin
          $error("unexpected result word for key %0h", result.out_key);
          fail_count++;
        end else begin
          want = owed_msgs.pop_front();
          if (result.status !== want.status) begin
            $error("status expected %0h got %0h", want.status, result.status);
            fail_count++;
          end
          if (result.msg_kind !== want.msg_kind) begin
            $error("msg_kind expected %0h got %0h", want.msg_kind, result.msg_kind);
            fail_count++;
          end
          if (result.to_all !== want.to_all) begin
            $error("to_all expected %0h got %0h", want.to_all, result.to_all);
            fail_count++;
          end
          if (result.target_system !== want.target_system) begin
            $error("target_system expected %0h got %0h", want.target_system,
                   result.target_system);
            fail_count++;
          end
          if (result.out_key !== want.out_key) begin
            $error("out_key expected %0h got %0h", want.out_key, result.out_key);
            fail_count++;
          end
          if (result.out_cost !== want.out_cost) begin
            $error("out_cost expected %0h got %0h", want.out_cost, result.out_cost);
            fail_count++;
          end
        end
        hold = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // hang detection: too long with no word moving on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("distance_vector_route_update_unit verification failed");
        $finish;
      end
    end
  end

endmodule
